>>> src/rcid_pkg.sv
package rcid_pkg;

    localparam int ID_W     = 8;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;
    localparam int CNT_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Operation codes; unused codes behave as a lookup.
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_INCR   = 3'd3;
    localparam logic [OP_W-1:0] OP_DECR   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [ST_W-1:0] ST_OUT_OF_IDS = 3'd2;
    localparam logic [ST_W-1:0] ST_ABOVE_MAX  = 3'd3;
    localparam logic [ST_W-1:0] ST_PRESENT    = 3'd4;

    // Register word index and reset value.
    localparam logic REG_MAX_ID = 1'b0;
    localparam logic [ID_W-1:0] MAX_ID_RESET = 8'd255;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_MODIFY
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic alloc_done;
        logic alloc_fail;
        logic check_done;
        logic read_issue;
        logic modify_done;
    } dp_cmd_t;

    typedef struct packed {
        logic in_alloc;
        logic scan_hit;
        logic scan_end;
        logic need_read;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/rcid_if.sv
interface rcid_in_if;
    logic                        valid;
    logic                        ready;
    logic [rcid_pkg::OP_W-1:0]   opcode;
    logic [rcid_pkg::ID_W-1:0]   target_id;

    modport source (output valid, opcode, target_id, input ready);
    modport sink   (input valid, opcode, target_id, output ready);
endinterface

interface rcid_out_if;
    logic                        valid;
    logic                        ready;
    logic [rcid_pkg::ID_W-1:0]   result_id;
    logic [rcid_pkg::ST_W-1:0]   status;
    logic [rcid_pkg::CNT_W-1:0]  ref_count;
    logic                        freed;

    modport source (output valid, result_id, status, ref_count, freed, input ready);
    modport sink   (input valid, result_id, status, ref_count, freed, output ready);
endinterface

>>> src/refcounted_id_allocator.sv
// New or out-of-range inserts, and lookup/increment/decrement misses, end in S_CHECK.
// Lookup, increment, decrement and duplicate insert go on to S_MODIFY for the count RAM read.
// Allocate sweeps from the allocation pointer past k taken IDs, k from 0 to max_id;
// the sweep tests one present bit per cycle. One item is in flight at a time.
// Reset (rst_n low, asynchronous) clears all present bits, the allocation pointer and
// the output valid, and sets max_id to 255. Counts are undefined until written.
module refcounted_id_allocator #(
    parameter int ID_SLOTS   = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rcid_in_if.sink                       cmd,
    rcid_out_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcid_pkg::APB_AW-1:0]   paddr,
    input  logic [rcid_pkg::APB_DW-1:0]   pwdata,
    output logic [rcid_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [rcid_pkg::ID_W-1:0] max_id_reg;
    logic [rcid_pkg::ID_W-1:0] max_id_next;
    logic                      reg_sel;

    rcid_pkg::dp_cmd_t    dp_cmd;
    rcid_pkg::dp_status_t dp_sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == rcid_pkg::REG_MAX_ID);

    always_comb
    begin
        max_id_next = max_id_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            max_id_next = pwdata[rcid_pkg::ID_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_id_reg <= rcid_pkg::MAX_ID_RESET;
        end
        else
        begin
            max_id_reg <= max_id_next;
        end
    end

    assign prdata = reg_sel ? {24'b0, max_id_reg} : '0;

    rcid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    rcid_datapath #(
        .ID_SLOTS   (ID_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_id        (max_id_reg),
        .in_opcode     (cmd.opcode),
        .in_target_id  (cmd.target_id),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .out_result_id (rsp.result_id),
        .out_status    (rsp.status),
        .out_ref_count (rsp.ref_count),
        .out_freed     (rsp.freed),
        .cmd           (dp_cmd),
        .sts           (dp_sts)
    );

    // A freeing decrement always reports success with a zero count.
    a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.freed |-> rsp.status == rcid_pkg::ST_OK && rsp.ref_count == '0)
        else $error("freed beat with bad status or count");

    // Exhaustion reports ID zero and count zero.
    a_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == rcid_pkg::ST_OUT_OF_IDS |->
        rsp.result_id == '0 && rsp.ref_count == '0 && !rsp.freed)
        else $error("out-of-ids beat with nonzero fields");

    // After an item is taken the block works on it before taking another.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("second item accepted while busy");

endmodule

>>> src/rcid_ram.sv
module rcid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/rcid_ctrl.sv
module rcid_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rcid_pkg::dp_status_t  sts,
    output rcid_pkg::dp_cmd_t     cmd
);

    rcid_pkg::state_t state_reg;
    rcid_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcid_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcid_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.in_alloc ? rcid_pkg::S_SCAN : rcid_pkg::S_CHECK;
                end
            end
            rcid_pkg::S_SCAN:
            begin
                if ((sts.scan_end || sts.scan_hit) && sts.out_free)
                begin
                    state_next = rcid_pkg::S_IDLE;
                end
            end
            rcid_pkg::S_CHECK:
            begin
                if (sts.need_read)
                begin
                    state_next = rcid_pkg::S_MODIFY;
                end
                else if (sts.out_free)
                begin
                    state_next = rcid_pkg::S_IDLE;
                end
            end
            rcid_pkg::S_MODIFY:
            begin
                if (sts.out_free)
                begin
                    state_next = rcid_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rcid_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            rcid_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rcid_pkg::S_SCAN:
            begin
                // Limit tested before the candidate; IDs 1 to the limit each get one try.
                if (sts.scan_end)
                begin
                    cmd.alloc_fail = sts.out_free;
                end
                else if (sts.scan_hit)
                begin
                    cmd.alloc_done = sts.out_free;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            rcid_pkg::S_CHECK:
            begin
                if (sts.need_read)
                begin
                    cmd.read_issue = 1'b1;
                end
                else
                begin
                    cmd.check_done = sts.out_free;
                end
            end
            rcid_pkg::S_MODIFY:
            begin
                cmd.modify_done = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/rcid_datapath.sv
module rcid_datapath #(
    parameter int ID_SLOTS   = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rcid_pkg::ID_W-1:0]   max_id,
    input  logic [rcid_pkg::OP_W-1:0]   in_opcode,
    input  logic [rcid_pkg::ID_W-1:0]   in_target_id,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [rcid_pkg::ID_W-1:0]   out_result_id,
    output logic [rcid_pkg::ST_W-1:0]   out_status,
    output logic [rcid_pkg::CNT_W-1:0]  out_ref_count,
    output logic                        out_freed,
    input  rcid_pkg::dp_cmd_t           cmd,
    output rcid_pkg::dp_status_t        sts
);

    // Only IDs below 256 can be named, so the table never needs more rows.
    localparam int CD = (ID_SLOTS < 256) ? ID_SLOTS : 256;
    localparam int IW = $clog2(CD);
    localparam logic [rcid_pkg::ID_W-1:0] TOP_ID =
        (ID_SLOTS > 256) ? 8'd255 : 8'(ID_SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [rcid_pkg::OP_W-1:0]  op_reg, op_next;
    logic [rcid_pkg::ID_W-1:0]  id_reg, id_next;
    logic [rcid_pkg::ID_W-1:0]  last_id_reg, last_id_next;
    logic [rcid_pkg::ID_W-1:0]  scan_reg, scan_next;
    logic [rcid_pkg::ID_W-1:0]  iter_reg, iter_next;
    logic [CD-1:0]              present_reg, present_next;

    logic                       out_valid_reg, out_valid_next;
    logic [rcid_pkg::ID_W-1:0]  rid_reg, rid_next;
    logic [rcid_pkg::ST_W-1:0]  st_reg, st_next;
    logic [rcid_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       freed_reg, freed_next;

    logic [rcid_pkg::ID_W-1:0]  lim;
    logic [rcid_pkg::ID_W:0]    cand_sum;
    logic [rcid_pkg::ID_W-1:0]  cand;
    logic [IW-1:0]              cand_idx;
    logic [IW-1:0]              id_idx;
    logic                       in_table;
    logic                       id_present;

    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [COUNT_BITS-1:0]      ram_wdata;
    logic                       ram_re;
    logic [COUNT_BITS-1:0]      ram_rdata;

    logic                       res_load;
    logic [COUNT_BITS-1:0]      res_cnt;
    logic [COUNT_BITS+15:0]     res_cnt_ext;
    logic [COUNT_BITS-1:0]      cnt_dec;

    assign lim      = (max_id > TOP_ID) ? TOP_ID : max_id;
    assign cand_sum = {1'b0, scan_reg} + 9'd1;
    assign cand     = (cand_sum > {1'b0, lim}) ? 8'd1 : cand_sum[rcid_pkg::ID_W-1:0];
    assign cand_idx = cand[IW-1:0];
    assign id_idx   = id_reg[IW-1:0];
    assign in_table = (id_reg <= TOP_ID);
    assign id_present = present_reg[id_idx];
    assign cnt_dec  = (ram_rdata == '0) ? '0 : ram_rdata - CNT_ONE;

    assign sts.in_alloc  = (in_opcode == rcid_pkg::OP_ALLOC);
    assign sts.scan_hit  = !present_reg[cand_idx];
    assign sts.scan_end  = (iter_reg == lim);
    assign sts.need_read = (op_reg == rcid_pkg::OP_INSERT) ?
                           ((id_reg <= lim) && id_present) : (in_table && id_present);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        op_next      = op_reg;
        id_next      = id_reg;
        last_id_next = last_id_reg;
        scan_next    = scan_reg;
        iter_next    = iter_reg;
        present_next = present_reg;
        ram_we       = 1'b0;
        ram_waddr    = id_idx;
        ram_wdata    = CNT_ONE;
        ram_re       = 1'b0;
        res_load     = 1'b0;
        rid_next     = id_reg;
        st_next      = rcid_pkg::ST_OK;
        res_cnt      = '0;
        freed_next   = 1'b0;

        if (cmd.load)
        begin
            op_next   = in_opcode;
            id_next   = in_target_id;
            scan_next = last_id_reg;
            iter_next = '0;
        end

        if (cmd.scan_step)
        begin
            scan_next = cand;
            iter_next = iter_reg + 8'd1;
        end

        if (cmd.alloc_done)
        begin
            present_next[cand_idx] = 1'b1;
            ram_we       = 1'b1;
            ram_waddr    = cand_idx;
            last_id_next = cand;
            res_load     = 1'b1;
            rid_next     = cand;
            res_cnt      = CNT_ONE;
        end

        if (cmd.alloc_fail)
        begin
            res_load = 1'b1;
            rid_next = '0;
            st_next  = rcid_pkg::ST_OUT_OF_IDS;
        end

        if (cmd.check_done)
        begin
            res_load = 1'b1;
            if (op_reg == rcid_pkg::OP_INSERT)
            begin
                if (id_reg > lim)
                begin
                    st_next = rcid_pkg::ST_ABOVE_MAX;
                end
                else
                begin
                    present_next[id_idx] = 1'b1;
                    ram_we  = 1'b1;
                    res_cnt = CNT_ONE;
                end
            end
            else
            begin
                st_next = in_table ? rcid_pkg::ST_NOT_FOUND : rcid_pkg::ST_ABOVE_MAX;
            end
        end

        ram_re = cmd.read_issue;

        if (cmd.modify_done)
        begin
            res_load = 1'b1;
            case (op_reg)
                rcid_pkg::OP_INSERT:
                begin
                    st_next = rcid_pkg::ST_PRESENT;
                    res_cnt = ram_rdata;
                end
                rcid_pkg::OP_INCR:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_ONE;
                    res_cnt   = ram_wdata;
                end
                rcid_pkg::OP_DECR:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = cnt_dec;
                    res_cnt   = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        present_next[id_idx] = 1'b0;
                        freed_next = 1'b1;
                    end
                end
                default:
                begin
                    res_cnt = ram_rdata;
                end
            endcase
        end

        res_cnt_ext = {16'b0, res_cnt};
        cnt_next    = res_cnt_ext[rcid_pkg::CNT_W-1:0];

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_id_reg   <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_id_reg   <= last_id_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        id_reg   <= id_next;
        scan_reg <= scan_next;
        iter_reg <= iter_next;
        if (res_load)
        begin
            rid_reg   <= rid_next;
            st_reg    <= st_next;
            cnt_reg   <= cnt_next;
            freed_reg <= freed_next;
        end
    end

    rcid_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CD)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (id_idx),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign out_result_id = rid_reg;
    assign out_status    = st_reg;
    assign out_ref_count = cnt_reg;
    assign out_freed     = freed_reg;

endmodule
